@@ src/dblc_pkg.sv @@
// shared types and constants of the double buffered line collector
package dblc_pkg;

  localparam int unsigned LINE_LEN_DEF = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;

  localparam logic [1:0] STATUS_CHAR  = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EOL   = 2'd1,
    KIND_FETCH = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } word_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } queue_head_t;

endpackage

@@ src/dblc_front.sv @@
// front end: takes commands and sorts them into characters, line ends and fetches
module dblc_front (
  input  logic             start_i,
  input  logic             mode_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             full_i,
  output logic             busy_o,
  output logic             push_o,
  output dblc_pkg::word_t  word_o
);

  assign busy_o = full_i;
  assign push_o = start_i & ~full_i;

  always_comb begin
    word_o.data = rx_byte_i;
    if (mode_i) begin
      word_o.kind = dblc_pkg::KIND_FETCH;
    end else if (rx_byte_i == dblc_pkg::CHAR_LF || rx_byte_i == dblc_pkg::CHAR_CR) begin
      word_o.kind = dblc_pkg::KIND_EOL;
    end else begin
      word_o.kind = dblc_pkg::KIND_CHAR;
    end
  end

endmodule

@@ src/dblc_queue.sv @@
// two entry queue between front end and back end
module dblc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dblc_pkg::word_t        word_i,
  input  logic                   pop_i,
  output logic                   full_o,
  output dblc_pkg::queue_head_t  head_o
);

  localparam int unsigned PW = $clog2(dblc_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(dblc_pkg::QUEUE_DEPTH + 1);

  dblc_pkg::word_t entry_q [dblc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CW'(dblc_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.word  = entry_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(dblc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(dblc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

@@ src/dblc_back.sv @@
// back end: line buffers, ready line tracking and fetch sequencer
module dblc_back #(
  parameter int unsigned LINE_LEN = dblc_pkg::LINE_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dblc_pkg::queue_head_t  head_i,
  output logic                   pop_o,
  output logic                   strobe_o,
  output logic [1:0]             status_o,
  output logic [7:0]             char_out_o,
  output logic                   last_o
);

  localparam int unsigned IW = $clog2(LINE_LEN + 1);
  localparam int unsigned AW = (2 * LINE_LEN > 1) ? $clog2(2 * LINE_LEN) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_STREAM = 4'b0100,
    ST_TAIL   = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic          fill_buf_q, fill_buf_d;
  logic [IW-1:0] fill_cnt_q, fill_cnt_d;
  logic          rdy_q, rdy_d;
  logic [IW-1:0] rdy_len_q, rdy_len_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    hold_q, hold_d;
  logic          strobe_q, strobe_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    char_q, char_d;
  logic          last_q, last_d;

  logic [7:0]    mem [2 * LINE_LEN];
  logic [7:0]    rdata_q;
  logic          we, re;
  logic [IW-1:0] wr_idx, rd_idx, idx_inc;
  logic [AW-1:0] waddr, raddr;
  logic          fill_full;

  assign fill_full = (fill_cnt_q >= IW'(LINE_LEN));
  assign wr_idx    = fill_full ? '0 : fill_cnt_q;
  assign idx_inc   = idx_q + 1'b1;
  assign rd_idx    = (state_q == ST_IDLE) ? '0 : idx_inc;
  assign re        = (rd_idx < IW'(LINE_LEN));
  assign waddr     = (fill_buf_q ? AW'(LINE_LEN) : '0) + AW'(wr_idx);
  assign raddr     = (fill_buf_q ? '0 : AW'(LINE_LEN)) + AW'(rd_idx);

  always_comb begin
    state_d    = state_q;
    fill_buf_d = fill_buf_q;
    fill_cnt_d = fill_cnt_q;
    rdy_d      = rdy_q;
    rdy_len_d  = rdy_len_q;
    idx_d      = idx_q;
    hold_d     = hold_q;
    strobe_d   = 1'b0;
    status_d   = dblc_pkg::STATUS_CHAR;
    char_d     = '0;
    last_d     = 1'b0;
    pop_o      = 1'b0;
    we         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.word.kind)
            dblc_pkg::KIND_CHAR: begin
              we         = 1'b1;
              fill_cnt_d = wr_idx + 1'b1;
            end
            dblc_pkg::KIND_EOL: begin
              if (fill_cnt_q != '0) begin
                if (!rdy_q) begin
                  rdy_d      = 1'b1;
                  rdy_len_d  = fill_cnt_q;
                  fill_buf_d = ~fill_buf_q;
                end
                fill_cnt_d = '0;
              end
            end
            dblc_pkg::KIND_FETCH: begin
              if (!rdy_q) begin
                strobe_d = 1'b1;
                status_d = dblc_pkg::STATUS_NONE;
                last_d   = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (rdata_q == 8'h00) begin
          strobe_d  = 1'b1;
          status_d  = dblc_pkg::STATUS_EMPTY;
          last_d    = 1'b1;
          rdy_d     = 1'b0;
          rdy_len_d = '0;
          state_d   = ST_IDLE;
        end else begin
          hold_d = rdata_q;
          if (idx_inc == rdy_len_q) begin
            state_d = ST_TAIL;
          end else begin
            idx_d   = idx_inc;
            state_d = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        strobe_d = 1'b1;
        char_d   = hold_q;
        if (rdata_q == 8'h00) begin
          last_d    = 1'b1;
          rdy_d     = 1'b0;
          rdy_len_d = '0;
          state_d   = ST_IDLE;
        end else begin
          hold_d = rdata_q;
          if (idx_inc == rdy_len_q) begin
            state_d = ST_TAIL;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      ST_TAIL: begin
        strobe_d  = 1'b1;
        char_d    = hold_q;
        last_d    = 1'b1;
        rdy_d     = 1'b0;
        rdy_len_d = '0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_buf_q <= 1'b0;
      fill_cnt_q <= '0;
      rdy_q      <= 1'b0;
      rdy_len_q  <= '0;
      idx_q      <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_buf_q <= fill_buf_d;
      fill_cnt_q <= fill_cnt_d;
      rdy_q      <= rdy_d;
      rdy_len_q  <= rdy_len_d;
      idx_q      <= idx_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q   <= hold_d;
    status_q <= status_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  // line buffer memory, both halves
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= head_i.word.data;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign strobe_o   = strobe_q;
  assign status_o   = status_q;
  assign char_out_o = char_q;
  assign last_o     = last_q;

endmodule

@@ src/double_buffered_line_collector.sv @@
// top level of the double buffered line collector
//
// Command channel: a word is taken when start is high and busy is low.
// mode_i low hands over a received byte in rx_byte_i; CR or LF ends a
// non-empty line, which becomes the ready line if none is waiting and is
// dropped otherwise. mode_i high fetches the ready line.
// Result channel: strobe_o marks each result for one cycle; status_o,
// char_out_o and last_o are valid with it. The receiver cannot stall.
// A fetch emits the line one character a cycle, last_o on the final one,
// or a single word with status no-line or empty-line.
// Order: a taken command is written into the queue, and the back end
// pops it from the queue head while idle. A fetch with no ready line
// gives its no-line result straight from the popped command; otherwise
// the back end reads the first byte of the line in ST_READ, which gives
// the empty-line result if that byte is zero, and then emits one
// character every cycle in ST_STREAM and ST_TAIL. Commands wait in a
// two word queue while a fetch runs; busy is high while it is full.
// Reset clears the queue, the ready line and the fill count; the line
// buffer contents are left as they are.
module double_buffered_line_collector #(
  parameter int unsigned LINE_LEN = dblc_pkg::LINE_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       mode_i,
  input  logic [7:0] rx_byte_i,
  output logic       strobe_o,
  output logic [1:0] status_o,
  output logic [7:0] char_out_o,
  output logic       last_o
);

  logic                  full, push, pop;
  dblc_pkg::word_t       word;
  dblc_pkg::queue_head_t head;

  dblc_front u_front (
    .start_i   (start),
    .mode_i    (mode_i),
    .rx_byte_i (rx_byte_i),
    .full_i    (full),
    .busy_o    (busy),
    .push_o    (push),
    .word_o    (word)
  );

  dblc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .word_i (word),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  dblc_back #(
    .LINE_LEN (LINE_LEN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .strobe_o   (strobe_o),
    .status_o   (status_o),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

endmodule

@@ src/dblc_checker.sv @@
// port level checks of the line collector and their bind
module dblc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       strobe_o,
  input logic [1:0] status_o,
  input logic [7:0] char_out_o,
  input logic       last_o
);

  // status codes beyond empty line never appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> status_o != 2'd3)
  else $error("bad status code");

  // non-character results close a fetch on their own
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != dblc_pkg::STATUS_CHAR |-> last_o)
  else $error("status word without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != dblc_pkg::STATUS_CHAR |-> char_out_o == 8'h00)
  else $error("status word with character");

  // a line streams without gaps until its last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && status_o == dblc_pkg::STATUS_CHAR)
  else $error("gap inside fetched line");

endmodule

bind double_buffered_line_collector dblc_checker u_dblc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .strobe_o   (strobe_o),
  .status_o   (status_o),
  .char_out_o (char_out_o),
  .last_o     (last_o)
);

@@ tb/sv/double_buffered_line_collector_tb.sv @@
// self-checking testbench of the double buffered line collector
module double_buffered_line_collector_tb;

  localparam int unsigned LINE_LEN   = dblc_pkg::LINE_LEN_DEF;
  localparam bit          MODE_BYTE  = 1'b0;
  localparam bit          MODE_FETCH = 1'b1;
  localparam int          RANDOM_ITEMS = 140;

  localparam logic [7:0] CHAR_LF      = dblc_pkg::CHAR_LF;
  localparam logic [7:0] CHAR_CR      = dblc_pkg::CHAR_CR;
  localparam logic [1:0] STATUS_CHAR  = dblc_pkg::STATUS_CHAR;
  localparam logic [1:0] STATUS_NONE  = dblc_pkg::STATUS_NONE;
  localparam logic [1:0] STATUS_EMPTY = dblc_pkg::STATUS_EMPTY;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] ch;
    logic       last;
  } line_result_t;

  typedef struct packed {
    logic         m;
    logic [7:0]   b;
    logic [5:0]   reps;
    logic         typed;
    line_result_t want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       mode_i;
  logic [7:0] rx_byte_i;
  logic       strobe_o;
  logic [1:0] status_o;
  logic [7:0] char_out_o;
  logic       last_o;

  double_buffered_line_collector #(.LINE_LEN(LINE_LEN)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .mode_i    (mode_i),
    .rx_byte_i (rx_byte_i),
    .strobe_o  (strobe_o),
    .status_o  (status_o),
    .char_out_o(char_out_o),
    .last_o    (last_o)
  );

  // predictor state
  logic [7:0]  line_mem [2*LINE_LEN];
  bit          fill_sel;
  int unsigned fill_len;
  bit          line_waiting;
  int unsigned waiting_len;

  line_result_t expected_words [$];
  line_result_t fetch_words [$];
  stim_row_t    directed_rows [$];
  int           err_cnt;
  int           item_cnt;
  bit           quiet;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("double_buffered_line_collector_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_cnt++;
    $display("mismatch: %s got %h want %h", what, got, want);
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    if (b == CHAR_LF || b == CHAR_CR) begin
      if (fill_len == 0) return;
      if (!line_waiting) begin
        line_waiting = 1'b1;
        waiting_len  = fill_len;
        fill_sel     = ~fill_sel;
      end
      fill_len = 0;
      return;
    end
    if (fill_len >= LINE_LEN) fill_len = 0;
    line_mem[fill_sel * LINE_LEN + fill_len] = b;
    fill_len++;
  endtask

  task automatic fetch_ready_line();
    int unsigned base;
    int unsigned len;
    int unsigned n;
    fetch_words.delete();
    if (!line_waiting) begin
      fetch_words.push_back('{STATUS_NONE, 8'h00, 1'b1});
      return;
    end
    base = (fill_sel ? 0 : 1) * LINE_LEN;
    len  = (waiting_len > LINE_LEN) ? LINE_LEN : waiting_len;
    n    = 0;
    while (n < len && line_mem[base + n] != 8'h00) n++;
    line_waiting = 1'b0;
    waiting_len  = 0;
    if (n == 0) begin
      fetch_words.push_back('{STATUS_EMPTY, 8'h00, 1'b1});
      return;
    end
    for (int unsigned i = 0; i < n; i++)
      fetch_words.push_back('{STATUS_CHAR, line_mem[base + i], (i + 1 == n)});
  endtask

  task automatic idle_gap();
    int gap;
    if (quiet || $urandom_range(0, 99) >= 6) return;
    gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk_i);
      start     <= 1'b0;
      mode_i    <= 1'($urandom_range(0, 1));
      rx_byte_i <= 8'($urandom_range(0, 255));
    end
  endtask

  // hands one word over and returns once it has been taken
  task automatic send_word(input bit m, input logic [7:0] b);
    idle_gap();
    @(negedge clk_i);
    start     <= 1'b1;
    mode_i    <= m;
    rx_byte_i <= b;
    do @(posedge clk_i); while (busy !== 1'b0);
    item_cnt++;
    quiet = (item_cnt >= 30 && item_cnt < 110);
  endtask

  task automatic send_predicted(input bit m, input logic [7:0] b);
    send_word(m, b);
    if (m == MODE_BYTE) begin
      take_rx_byte(b);
    end else begin
      fetch_ready_line();
      foreach (fetch_words[i]) expected_words.push_back(fetch_words[i]);
    end
  endtask

  function automatic logic [7:0] rand_line_char();
    logic [7:0] b;
    if ($urandom_range(0, 15) == 0) return 8'h00;
    do b = 8'($urandom_range(1, 255)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni && strobe_o === 1'b1) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, char", char_out_o, 8'h00);
      end else begin
        want = expected_words.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 8'(status_o), 8'(want.status));
        if (char_out_o !== want.ch) report_mismatch("char_out", char_out_o, want.ch);
        if (last_o !== want.last) report_mismatch("last", 8'(last_o), 8'(want.last));
      end
    end
  end

  initial begin
    int len;
    int sel;
    int wait_cnt;
    start     = 1'b0;
    mode_i    = 1'b0;
    rx_byte_i = 8'h00;
    rst_ni    = 1'b0;
    err_cnt   = 0;
    item_cnt  = 0;
    quiet     = 1'b0;
    fill_sel     = 1'b0;
    fill_len     = 0;
    line_waiting = 1'b0;
    waiting_len  = 0;
    foreach (line_mem[i]) line_mem[i] = 8'h00;

    //                        mode        byte   reps typed want
    directed_rows.push_back('{MODE_FETCH, 8'h00, 6'd1, 1'b1, '{STATUS_NONE, 8'h00, 1'b1}});
    directed_rows.push_back('{MODE_BYTE,  CHAR_LF, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_CR, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  8'h00, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_CR, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_FETCH, 8'hff, 6'd1, 1'b1, '{STATUS_EMPTY, 8'h00, 1'b1}});
    directed_rows.push_back('{MODE_BYTE,  8'hff, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_LF, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_FETCH, 8'h00, 6'd1, 1'b1, '{STATUS_CHAR, 8'hff, 1'b1}});
    directed_rows.push_back('{MODE_BYTE,  8'h41, 6'd2, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_CR, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  8'h43, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_LF, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_FETCH, 8'h55, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_FETCH, 8'haa, 6'd1, 1'b1, '{STATUS_NONE, 8'h00, 1'b1}});
    directed_rows.push_back('{MODE_BYTE,  8'h78, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  8'h00, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_CR, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_FETCH, 8'h00, 6'd1, 1'b0, '0});
    // full buffer: the 33rd byte restarts the line
    directed_rows.push_back('{MODE_BYTE,  8'h20, 6'd33, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_CR, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_FETCH, 8'h00, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  8'h41, 6'd32, 1'b0, '0});
    directed_rows.push_back('{MODE_BYTE,  CHAR_LF, 6'd1, 1'b0, '0});
    directed_rows.push_back('{MODE_FETCH, 8'hff, 6'd1, 1'b0, '0});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].typed) begin
        send_word(directed_rows[r].m, directed_rows[r].b);
        fetch_ready_line();
        expected_words.push_back(directed_rows[r].want);
      end else begin
        for (int i = 0; i < directed_rows[r].reps; i++)
          send_predicted(directed_rows[r].m, 8'(directed_rows[r].b + i));
      end
    end

    item_cnt = 0;
    while (item_cnt < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 34) : $urandom_range(1, 8);
        repeat (len) send_predicted(MODE_BYTE, rand_line_char());
        send_predicted(MODE_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3))
            send_predicted(MODE_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else if (sel <= 7) begin
        send_predicted(MODE_FETCH, 8'($urandom_range(0, 255)));
      end else if (sel == 8) begin
        send_predicted(MODE_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_predicted(MODE_FETCH, 8'($urandom_range(0, 255)));
        send_predicted(MODE_FETCH, 8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    wait_cnt = 0;
    while (expected_words.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    if (expected_words.size() != 0)
      report_mismatch("words left over", 8'(expected_words.size()), 8'h00);
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0)
      $display("double_buffered_line_collector_tb OK");
    else
      $display("double_buffered_line_collector_tb NOT OK");
    $finish;
  end

endmodule
